/* rtl/chmc_pkg.sv */
// Shared types, sizes and helpers for the monotone chain convex hull block.
// Depends on nothing; the other RTL files but the checker refer to it by scoped names.
`default_nettype none
package chmc_pkg;

    localparam int MAX_POINTS  = 32;
    localparam int COORD_BITS  = 16;
    localparam int PIDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int STACK_DEPTH = 2 * MAX_POINTS;
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    // One classified input transfer on its way to the engine
    typedef struct packed {
        t_point pt;
        logic   last;
        logic   keep;
    } t_item;

    // Sort order: by x, ties broken by y
    function automatic logic sorts_before(input t_point a, input t_point b);
        logic res;
        if (a.x != b.x) begin
            res = (a.x < b.x);
        end else begin
            res = (a.y < b.y);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/chmc_front.sv */
// Front end: takes input transfers, tags each as kept or dropped.
// Depends on chmc_pkg.
`default_nettype none
module chmc_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire                                i_full,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_point_x,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_point_y,
    input  wire                                i_set_end,
    output logic                               o_push,
    output chmc_pkg::t_item                    o_item
);

    logic [chmc_pkg::CNT_W-1:0] r_cnt;
    logic                       w_keep;

    assign o_push = i_start && !i_full;
    assign w_keep = (r_cnt < chmc_pkg::CNT_W'(chmc_pkg::MAX_POINTS));

    always_comb begin
        o_item.pt.x = i_point_x;
        o_item.pt.y = i_point_y;
        o_item.last = i_set_end;
        o_item.keep = w_keep;
    end

    // Track the fill of the current set; drop points once it is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_set_end) begin
                r_cnt <= '0;
            end else if (w_keep) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/chmc_queue.sv */
// Two-entry queue between the front end and the hull engine.
// Depends on chmc_pkg.
`default_nettype none
module chmc_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  chmc_pkg::t_item i_item,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_valid,
    output chmc_pkg::t_item o_item
);

    chmc_pkg::t_item                r_mem [chmc_pkg::QUEUE_DEPTH];
    logic [chmc_pkg::QIDX_W-1:0]    r_wp;
    logic [chmc_pkg::QIDX_W-1:0]    r_rp;
    logic [chmc_pkg::QCNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == chmc_pkg::QCNT_W'(chmc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/chmc_engine.sv */
// Back end: stores points, sorts them, builds both chains, emits the hull.
// Depends on chmc_pkg; holds the point store and the hull stack memories.
`default_nettype none
module chmc_engine (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    input  chmc_pkg::t_item                       i_item,
    output logic                                  o_pop,
    output logic                                  o_strobe,
    output logic signed [chmc_pkg::COORD_BITS-1:0] o_hull_x,
    output logic signed [chmc_pkg::COORD_BITS-1:0] o_hull_y,
    output logic                                  o_final_vertex
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] ST_SRD   = 5'd1;
    localparam logic [ST_W-1:0] ST_SLD   = 5'd2;
    localparam logic [ST_W-1:0] ST_SCMP  = 5'd3;
    localparam logic [ST_W-1:0] ST_SPUT  = 5'd4;
    localparam logic [ST_W-1:0] ST_HINIT = 5'd5;
    localparam logic [ST_W-1:0] ST_HSEC  = 5'd6;
    localparam logic [ST_W-1:0] ST_CHK   = 5'd7;
    localparam logic [ST_W-1:0] ST_RB    = 5'd8;
    localparam logic [ST_W-1:0] ST_RC    = 5'd9;
    localparam logic [ST_W-1:0] ST_RD    = 5'd10;
    localparam logic [ST_W-1:0] ST_MUL   = 5'd11;
    localparam logic [ST_W-1:0] ST_DEC   = 5'd12;
    localparam logic [ST_W-1:0] ST_POP   = 5'd13;
    localparam logic [ST_W-1:0] ST_PUSH  = 5'd14;
    localparam logic [ST_W-1:0] ST_ES    = 5'd15;
    localparam logic [ST_W-1:0] ST_EP    = 5'd16;
    localparam logic [ST_W-1:0] ST_EO    = 5'd17;

    localparam int PW = chmc_pkg::PIDX_W;
    localparam int SW = chmc_pkg::SIDX_W;
    localparam int CW = chmc_pkg::CNT_W;
    localparam int DW = chmc_pkg::DIFF_W;

    // Memories
    chmc_pkg::t_point r_pmem [chmc_pkg::MAX_POINTS];
    logic [PW-1:0]    r_smem [chmc_pkg::STACK_DEPTH];
    chmc_pkg::t_point r_prd;
    logic [PW-1:0]    r_srd;

    logic             p_we;
    logic [PW-1:0]    p_wa;
    chmc_pkg::t_point p_wd;
    logic [PW-1:0]    p_ra;
    logic             s_we;
    logic [SW-1:0]    s_wa;
    logic [PW-1:0]    s_wd;
    logic [SW-1:0]    s_ra;

    // Control and datapath registers
    logic [ST_W-1:0]  r_state;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_n;
    logic [PW-1:0]    r_i;
    logic [PW-1:0]    r_j;
    chmc_pkg::t_point r_cur;
    logic [SW-1:0]    r_top;
    logic [SW-1:0]    r_lower;
    logic             r_up;
    logic [PW-1:0]    r_s1;
    logic [PW-1:0]    r_s2;
    logic [SW-1:0]    r_emit;
    logic [SW-1:0]    r_k;
    chmc_pkg::t_point r_pa;
    chmc_pkg::t_point r_pb;
    logic signed [DW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [chmc_pkg::PROD_W-1:0] r_m1, r_m2;
    logic             r_strobe;
    logic             r_fin;
    logic signed [chmc_pkg::COORD_BITS-1:0] r_ox, r_oy;

    logic             w_cond;
    logic             w_before;
    logic [CW-1:0]    w_n;

    assign w_cond   = r_up ? (r_top > r_lower) : (r_top >= SW'(2));
    assign w_before = chmc_pkg::sorts_before(r_cur, r_prd);
    assign w_n      = i_item.keep ? (r_cnt + 1'b1) : r_cnt;
    assign o_pop    = (r_state == ST_IDLE) && i_valid;

    assign o_strobe       = r_strobe;
    assign o_final_vertex = r_fin;
    assign o_hull_x       = r_ox;
    assign o_hull_y       = r_oy;

    // Point store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[p_wa] <= p_wd;
        end
        r_prd <= r_pmem[p_ra];
    end

    // Hull stack of point indices
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_wa] <= s_wd;
        end
        r_srd <= r_smem[s_ra];
    end

    // Drive memory ports from the sequencer state
    always_comb begin
        p_we = 1'b0;
        p_wa = r_j;
        p_wd = r_cur;
        p_ra = r_i;
        s_we = 1'b0;
        s_wa = r_top;
        s_wd = r_i;
        s_ra = r_k;
        case (r_state)
            ST_IDLE: begin
                p_we = i_valid && i_item.keep;
                p_wa = r_cnt[PW-1:0];
                p_wd = i_item.pt;
            end
            ST_SLD: begin
                p_ra = r_i - 1'b1;
            end
            ST_SCMP: begin
                p_we = 1'b1;
                if (w_before) begin
                    p_wd = r_prd;
                    p_ra = r_j - PW'(2);
                end
            end
            ST_SPUT: begin
                p_we = 1'b1;
                p_wa = '0;
            end
            ST_HINIT: begin
                s_we = 1'b1;
                s_wa = '0;
                s_wd = '0;
            end
            ST_HSEC: begin
                s_we = 1'b1;
                s_wa = SW'(1);
                s_wd = PW'(1);
            end
            ST_CHK: begin
                p_ra = r_s2;
            end
            ST_RB: begin
                p_ra = r_s1;
            end
            ST_DEC: begin
                s_ra = r_top - SW'(3);
            end
            ST_PUSH: begin
                s_we = 1'b1;
            end
            ST_EP: begin
                p_ra = r_srd;
            end
            default: begin
            end
        endcase
    end

    // Sequence load, sort, chain building and emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_fin    <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_item.last) begin
                            r_n     <= w_n;
                            r_cnt   <= '0;
                            r_i     <= PW'(1);
                            r_state <= (w_n == CW'(1)) ? ST_HINIT : ST_SRD;
                        end else if (i_item.keep) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SLD;
                end
                ST_SLD: begin
                    r_cur   <= r_prd;
                    r_j     <= r_i;
                    r_state <= ST_SCMP;
                end
                ST_SCMP: begin
                    if (w_before) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= (r_j == PW'(1)) ? ST_SPUT : ST_SCMP;
                    end else if ((CW'(r_i) + 1'b1) == r_n) begin
                        r_state <= ST_HINIT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_SRD;
                    end
                end
                ST_SPUT: begin
                    if ((CW'(r_i) + 1'b1) == r_n) begin
                        r_state <= ST_HINIT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_SRD;
                    end
                end
                ST_HINIT: begin
                    if (r_n == CW'(1)) begin
                        r_top   <= SW'(1);
                        r_emit  <= SW'(1);
                        r_k     <= '0;
                        r_state <= ST_ES;
                    end else begin
                        r_state <= ST_HSEC;
                    end
                end
                ST_HSEC: begin
                    r_top <= SW'(2);
                    r_s2  <= '0;
                    r_s1  <= PW'(1);
                    if (r_n == CW'(2)) begin
                        r_up    <= 1'b1;
                        r_lower <= SW'(2);
                        r_i     <= '0;
                    end else begin
                        r_up <= 1'b0;
                        r_i  <= PW'(2);
                    end
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_state <= w_cond ? ST_RB : ST_PUSH;
                end
                ST_RB: begin
                    r_pa    <= r_prd;
                    r_state <= ST_RC;
                end
                ST_RC: begin
                    r_pb    <= r_prd;
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_x1    <= DW'(r_pb.x) - DW'(r_pa.x);
                    r_y1    <= DW'(r_pb.y) - DW'(r_pa.y);
                    r_x2    <= DW'(r_prd.x) - DW'(r_pb.x);
                    r_y2    <= DW'(r_prd.y) - DW'(r_pb.y);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_m1    <= r_x1 * r_y2;
                    r_m2    <= r_x2 * r_y1;
                    r_state <= ST_DEC;
                end
                ST_DEC: begin
                    if (r_m1 < r_m2) begin
                        r_top   <= r_top - 1'b1;
                        r_s1    <= r_s2;
                        r_state <= ST_POP;
                    end else begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_POP: begin
                    r_s2    <= r_srd;
                    r_state <= ST_CHK;
                end
                ST_PUSH: begin
                    r_top <= r_top + 1'b1;
                    r_s2  <= r_s1;
                    r_s1  <= r_i;
                    if (!r_up) begin
                        if ((CW'(r_i) + 1'b1) == r_n) begin
                            r_up    <= 1'b1;
                            r_lower <= r_top + 1'b1;
                            r_i     <= PW'(r_n - CW'(2));
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                        r_state <= ST_CHK;
                    end else if (r_i == '0) begin
                        r_emit  <= r_top;
                        r_k     <= '0;
                        r_state <= ST_ES;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= ST_CHK;
                    end
                end
                ST_ES: begin
                    r_state <= ST_EP;
                end
                ST_EP: begin
                    r_state <= ST_EO;
                end
                ST_EO: begin
                    r_strobe <= 1'b1;
                    r_fin    <= ((r_k + 1'b1) == r_emit);
                    r_k      <= r_k + 1'b1;
                    r_state  <= ((r_k + 1'b1) == r_emit) ? ST_IDLE : ST_ES;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EO) begin
            r_ox <= r_prd.x;
            r_oy <= r_prd.y;
        end
    end

endmodule
`default_nettype wire

/* rtl/convex_hull_monotone_chain_unit.sv */
// Top level of the monotone chain convex hull block.
// Depends on chmc_pkg, chmc_front, chmc_queue and chmc_engine.
//
// Usage:
//   Input channel: a point transfer takes place on a rising edge with
//   i_start high and o_busy low. i_set_end marks the last point of a set;
//   points beyond 32 in one set are dropped, an end mark still closes it.
//   Output channel: each hull vertex shows for one cycle with o_strobe high,
//   o_final_vertex marking the last one. The receiver cannot stall; results
//   are simply taken on the edge that ends the strobe cycle.
//   Timing: a two-entry queue separates the front end from the engine. While
//   the engine is idle it stores one point a cycle. On the end mark it runs
//   an insertion sort, then the chains: it seeds the stack, then for each
//   point tests the turn where one is due and pops or pushes, and then
//   reads out and emits the vertices one at a time. The single point store
//   port and the shared cross product unit serialise this work; the engine
//   takes no new points from the queue until the last vertex is out.
//   o_busy is high exactly while the queue is full, which happens only while the engine is working.
//   Reset (synchronous, active low) empties the queue, clears the set and
//   returns the engine to idle; the memories are not cleared.
`default_nettype none
module convex_hull_monotone_chain_unit (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_start,
    output logic                                   o_busy,
    input  wire signed [chmc_pkg::COORD_BITS-1:0]  i_point_x,
    input  wire signed [chmc_pkg::COORD_BITS-1:0]  i_point_y,
    input  wire                                    i_set_end,
    output logic                                   o_strobe,
    output logic signed [chmc_pkg::COORD_BITS-1:0] o_hull_x,
    output logic signed [chmc_pkg::COORD_BITS-1:0] o_hull_y,
    output logic                                   o_final_vertex
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_valid;
    chmc_pkg::t_item w_in_item;
    chmc_pkg::t_item w_q_item;

    assign o_busy = w_full;

    // Classify incoming transfers
    chmc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_full    (w_full),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_set_end (i_set_end),
        .o_push    (w_push),
        .o_item    (w_in_item)
    );

    // Decouple front end and engine
    chmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_item  (w_q_item)
    );

    // Sort, build the hull and emit
    chmc_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_hull_x       (o_hull_x),
        .o_hull_y       (o_hull_y),
        .o_final_vertex (o_final_vertex)
    );

endmodule
`default_nettype wire

/* rtl/chmc_checker.sv */
// Port-level checks for the convex hull unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module chmc_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_busy,
    input wire o_strobe,
    input wire o_final_vertex
);

    // The final flag only travels with a result
    a_final_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_vertex |-> o_strobe)
        else $error("final vertex flag without strobe");

    // Results never arrive in consecutive cycles
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results in consecutive cycles");

    // Reset leaves the block quiet and ready for transfers
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !o_busy))
        else $error("strobe or busy after reset");

endmodule

bind convex_hull_monotone_chain_unit chmc_checker u_chmc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_strobe       (o_strobe),
    .o_final_vertex (o_final_vertex)
);
`default_nettype wire

/* dv/hull_checker.sv */
// Checker for the convex hull unit: watches point transfers and hull vertices.
// Depends on chmc_pkg; predicts each set's hull and compares vertex by vertex.
module hull_checker (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire                                   i_busy,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_point_x,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_point_y,
    input  wire                                   i_set_end,
    input  wire                                   i_strobe,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_hull_x,
    input  wire signed [chmc_pkg::COORD_BITS-1:0] i_hull_y,
    input  wire                                   i_final_vertex,
    output int                                    o_errors,
    output int                                    o_pending,
    output int                                    o_vertices
);

    typedef struct {
        logic signed [chmc_pkg::COORD_BITS-1:0] x;
        logic signed [chmc_pkg::COORD_BITS-1:0] y;
        logic                                   fin;
    } t_vertex;

    logic signed [chmc_pkg::COORD_BITS-1:0] set_x [chmc_pkg::MAX_POINTS];
    logic signed [chmc_pkg::COORD_BITS-1:0] set_y [chmc_pkg::MAX_POINTS];
    int      set_size;
    t_vertex hull_q [$];

    // Signed turn of a->b->c; positive is left, negative a strict right turn
    function automatic longint turn_of(int a, int b, int c);
        longint x1, y1, x2, y2;
        x1 = longint'(set_x[b]) - longint'(set_x[a]);
        y1 = longint'(set_y[b]) - longint'(set_y[a]);
        x2 = longint'(set_x[c]) - longint'(set_x[b]);
        y2 = longint'(set_y[c]) - longint'(set_y[b]);
        return x1 * y2 - x2 * y1;
    endfunction

    // Sort the held set, build both chains and queue the vertices
    task automatic predict_hull();
        int n, j, top, lower_top;
        int chain [2*chmc_pkg::MAX_POINTS];
        logic signed [chmc_pkg::COORD_BITS-1:0] cx, cy;
        t_vertex v;
        n = set_size;
        for (int i = 1; i < n; i++) begin
            cx = set_x[i];
            cy = set_y[i];
            j = i;
            while (j > 0 && (cx < set_x[j-1] || (cx == set_x[j-1] && cy < set_y[j-1]))) begin
                set_x[j] = set_x[j-1];
                set_y[j] = set_y[j-1];
                j--;
            end
            set_x[j] = cx;
            set_y[j] = cy;
        end
        if (n == 1) begin
            v.x = set_x[0];
            v.y = set_y[0];
            v.fin = 1'b1;
            hull_q = {hull_q, v};
            return;
        end
        chain[0] = 0;
        chain[1] = 1;
        top = 2;
        for (int i = 2; i < n; i++) begin
            while (top >= 2 && turn_of(chain[top-2], chain[top-1], i) < 0) top--;
            chain[top++] = i;
        end
        lower_top = top;
        for (int i = n - 2; i >= 0; i--) begin
            while (top > lower_top && turn_of(chain[top-2], chain[top-1], i) < 0) top--;
            chain[top++] = i;
        end
        for (int i = 0; i + 1 < top; i++) begin
            v.x = set_x[chain[i]];
            v.y = set_y[chain[i]];
            v.fin = (i + 2 == top);
            hull_q = {hull_q, v};
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            set_size = 0;
            hull_q.delete();
            o_errors   <= 0;
            o_vertices <= 0;
        end else begin
            // Collect points; drop any beyond a full store
            if (i_start && !i_busy) begin
                if (set_size < chmc_pkg::MAX_POINTS) begin
                    set_x[set_size] = i_point_x;
                    set_y[set_size] = i_point_y;
                    set_size = set_size + 1;
                end
                if (i_set_end) begin
                    predict_hull();
                    set_size = 0;
                end
            end
            // Compare each vertex against the oldest prediction
            if (i_strobe) begin
                o_vertices <= o_vertices + 1;
                if (hull_q.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d", i_hull_x, i_hull_y);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hull_q.pop_front();
                    if (want.x !== i_hull_x || want.y !== i_hull_y
                            || want.fin !== i_final_vertex) begin
                        if (want.x !== i_hull_x)
                            $error("hull_x expected %0d got %0d", want.x, i_hull_x);
                        if (want.y !== i_hull_y)
                            $error("hull_y expected %0d got %0d", want.y, i_hull_y);
                        if (want.fin !== i_final_vertex)
                            $error("final_vertex expected %0b got %0b", want.fin,
                                i_final_vertex);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= hull_q.size();
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for the convex hull unit: clock, reset, point stimulus, verdict.
// Depends on chmc_pkg, convex_hull_monotone_chain_unit and hull_checker.
module tb_top;

    localparam int CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [chmc_pkg::COORD_BITS-1:0] i_point_x = '0;
    logic signed [chmc_pkg::COORD_BITS-1:0] i_point_y = '0;
    logic i_set_end = 1'b0;
    wire  o_busy, o_strobe, o_final_vertex;
    wire  signed [chmc_pkg::COORD_BITS-1:0] o_hull_x, o_hull_y;
    int   errors, pending, vertices;
    int   cycles = 0;
    int   points_sent = 0;
    int   sets_sent = 0;

    always #10 i_clk = ~i_clk;

    convex_hull_monotone_chain_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_set_end(i_set_end),
        .o_strobe(o_strobe), .o_hull_x(o_hull_x), .o_hull_y(o_hull_y),
        .o_final_vertex(o_final_vertex)
    );

    hull_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_set_end(i_set_end),
        .i_strobe(o_strobe), .i_hull_x(o_hull_x), .i_hull_y(o_hull_y),
        .i_final_vertex(o_final_vertex), .o_errors(errors), .o_pending(pending),
        .o_vertices(vertices)
    );

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one point and hold it until the transfer
    task automatic send_point(input logic signed [chmc_pkg::COORD_BITS-1:0] x,
                              input logic signed [chmc_pkg::COORD_BITS-1:0] y,
                              input logic last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_set_end <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        points_sent++;
        if (last) sets_sent++;
    endtask

    function automatic logic signed [chmc_pkg::COORD_BITS-1:0] rand_coord(input int mode);
        case (mode)
            0:       return chmc_pkg::COORD_BITS'(int'($urandom_range(0, 8)) - 4);
            1:       return chmc_pkg::COORD_BITS'(int'($urandom_range(0, 200)) - 100);
            default: return chmc_pkg::COORD_BITS'($urandom());
        endcase
    endfunction

    // One random set; size mostly small, occasionally overflowing the store
    task automatic send_random_set();
        int n, mode;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single point at the extremes, a pair, collinear run,
        // duplicates and a square with an interior point
        send_point(-32768, 32767, 1'b1);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, -32768, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(3, 3, 1'b1);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b1);
        send_point(32767, 32767, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, -32768, 1'b1);
        i_start <= 1'b0;
        // Hold off until the directed hulls have all come back
        drain();

        // Overfull store: 34 points, the end mark on a dropped one
        for (int i = 0; i < 34; i++)
            send_point(rand_coord(2), rand_coord(2), i == 33);

        while (points_sent < 360) send_random_set();
        i_start <= 1'b0;
        drain();

        $display("Sent %0d points in %0d sets; checked %0d hull vertices.",
            points_sent, sets_sent, vertices);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* convex_hull_monotone_chain_unit.f */
rtl/chmc_pkg.sv
rtl/chmc_front.sv
rtl/chmc_queue.sv
rtl/chmc_engine.sv
rtl/convex_hull_monotone_chain_unit.sv
rtl/chmc_checker.sv
dv/hull_checker.sv
dv/tb_top.sv
